### hdl/tmsq_pkg.sv
// ----------------------------------------------------------------------------
// tmsq_pkg: shared types and constants of the tile map store
// Sizes of the cell store, field widths, mode and register codes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tmsq_pkg;

  // Map geometry and cell contents
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FLAG_BITS  = 8;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Field widths fixed by the interface
  localparam int DIM_W   = 9;   // map size and window indices
  localparam int CELL_W  = 8;   // cell value on the ports
  localparam int COORD_W = 32;  // coordinates and 16.16 edges
  localparam int TS_W    = 31;  // tile size
  localparam int NUM_W   = 33;  // edge minus origin, and its magnitude
  localparam int TILE_W  = 35;  // signed tile index before clamping
  localparam int IDX_W   = 3;   // configuration register index

  localparam logic [FLAG_BITS-1:0] FLAGS_NONE = '0;

  localparam logic [TS_W-1:0]  TS_RESET = TS_W'(1048576);
  localparam logic [TS_W-1:0]  TS_MIN   = TS_W'(2);
  localparam logic [DIM_W-1:0] MW_LIMIT = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MH_LIMIT = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] MW_RESET = (MAX_WIDTH < 256) ? DIM_W'(MAX_WIDTH) : DIM_W'(256);
  localparam logic [DIM_W-1:0] MH_RESET = (MAX_HEIGHT < 256) ? DIM_W'(MAX_HEIGHT) : DIM_W'(256);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_TILE_SIZE  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_MAP_WIDTH  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_MAP_HEIGHT = 3'd4;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_READ   = 2'd2,
    MODE_WINDOW = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ADDR,
    ST_WRITE,
    ST_READ,
    ST_SUB,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FLOOR,
    ST_DONE
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the item
    logic clear_step;  // zero one cell of the clearing pass
    logic addr_calc;   // form the cell address from the walk position
    logic mem_we;      // write the cell
    logic mem_re;      // read the cell into the result
    logic walk_step;   // advance the rectangle walk
    logic sub;         // form edge minus origin for the current lane
    logic div_start;   // launch the divider
    logic lane_store;  // floor, clamp and keep one window index
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  clear_done;
    logic  walk_en;
    logic  walk_last;
    logic  div_idle;
    logic  lane_last;
  } dp_stat_t;

endpackage

### hdl/tmsq_div.sv
// ----------------------------------------------------------------------------
// tmsq_div: serial unsigned divider
// Restoring division of a 33-bit magnitude by the tile size, one quotient
// bit per cycle. Reports the quotient and whether the remainder is nonzero.
// ----------------------------------------------------------------------------
module tmsq_div
  import tmsq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  dividend_i,
  input  logic [TS_W-1:0]   divisor_i,
  output logic              idle_o,
  output logic [NUM_W-1:0]  quot_o,
  output logic              rem_nz_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [TS_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [TS_W:0]    trial;
  logic [TS_W+1:0]  diff;
  logic             ge;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = {1'b0, trial} - {2'b00, divisor_i};
    ge    = ~diff[TS_W+1];
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
      rem_d = '0;
      quo_d = dividend_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      rem_d = ge ? diff[TS_W-1:0] : trial[TS_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
    end
  end

  // Hold the step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold remainder and quotient
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign idle_o   = (cnt_q == '0);
  assign quot_o   = quo_q;
  assign rem_nz_o = |rem_q;

endmodule

### hdl/tmsq_dp.sv
// ----------------------------------------------------------------------------
// tmsq_dp: datapath of the tile map store
// Configuration registers, item capture, rectangle walk, cell memory with
// its clearing pass, and the window lanes around the serial divider.
// ----------------------------------------------------------------------------
module tmsq_dp
  import tmsq_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   cmd_i,
  output dp_stat_t                  stat_o,
  input  logic                      cfg_we_i,
  input  logic [IDX_W-1:0]          cfg_idx_i,
  input  logic [COORD_W-1:0]        cfg_wdata_i,
  input  logic [1:0]                mode_i,
  input  logic signed [COORD_W-1:0] col_a_i,
  input  logic signed [COORD_W-1:0] row_a_i,
  input  logic [COORD_W-1:0]        col_b_i,
  input  logic [COORD_W-1:0]        row_b_i,
  input  logic [CELL_W-1:0]         tile_value_i,
  input  logic signed [COORD_W-1:0] probe_min_x_i,
  input  logic signed [COORD_W-1:0] probe_min_y_i,
  input  logic signed [COORD_W-1:0] probe_max_x_i,
  input  logic signed [COORD_W-1:0] probe_max_y_i,
  output logic [CELL_W-1:0]         cell_value_o,
  output logic [DIM_W-1:0]          win_col_lo_o,
  output logic [DIM_W-1:0]          win_row_lo_o,
  output logic [DIM_W-1:0]          win_col_hi_o,
  output logic [DIM_W-1:0]          win_row_hi_o
);

  // Configuration
  logic signed [COORD_W-1:0] origin_x_q, origin_y_q;
  logic [TS_W-1:0]           tile_size_q;
  logic [DIM_W-1:0]          map_w_q, map_h_q;

  // Captured item and walk position
  mode_e                     mode_q;
  logic [FLAG_BITS-1:0]      value_q;
  logic [DIM_W-1:0]          x0_q, cur_x_q, cur_y_q, xe_q, ye_q;
  logic                      walk_en_q;
  logic signed [COORD_W-1:0] pmin_x_q, pmin_y_q, pmax_x_q, pmax_y_q;

  // Memory
  logic [FLAG_BITS-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]    addr_q;
  logic [ADDR_W:0]      clr_q;
  logic [ADDR_W-1:0]    wr_addr;
  logic [FLAG_BITS-1:0] wr_data;
  logic                 wr_en;
  logic [CELL_W-1:0]    cell_q;

  // Window lanes
  logic [1:0]                lane_q;
  logic signed [NUM_W-1:0]   num_q;
  logic                      neg_q;
  logic [DIM_W-1:0]          win_q [4];

  // Load decode
  mode_e             mode_in;
  logic [COORD_W-1:0] ua, ub, mw32, mh32;
  logic [DIM_W-1:0]   xe_fill, ye_fill;
  logic               in_map, fill_en;

  // Address, walk and lane logic
  logic [ROW_W+DIM_W-1:0]    prod;
  logic [DIM_W-1:0]          x_nxt, y_nxt;
  logic signed [COORD_W-1:0] probe_sel, org_sel;
  logic [NUM_W-1:0]          dividend;
  logic [NUM_W-1:0]          quot;
  logic                      rem_nz, div_idle;
  logic                      lane_hi;
  logic [1:0]                neg_adj;
  logic [TILE_W-1:0]         tq;
  logic [DIM_W-1:0]          limit, clamped;

  // Write configuration registers, forcing tile size and map size into range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      tile_size_q <= TS_RESET;
      map_w_q     <= MW_RESET;
      map_h_q     <= MH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIGIN_X: origin_x_q <= signed'(cfg_wdata_i);
        CFG_ORIGIN_Y: origin_y_q <= signed'(cfg_wdata_i);
        CFG_TILE_SIZE: begin
          if (cfg_wdata_i[TS_W-1:0] < TS_MIN) begin
            tile_size_q <= TS_MIN;
          end else begin
            tile_size_q <= {cfg_wdata_i[TS_W-1:1], 1'b0};
          end
        end
        CFG_MAP_WIDTH: begin
          map_w_q <= (cfg_wdata_i[DIM_W-1:0] > MW_LIMIT) ? MW_LIMIT : cfg_wdata_i[DIM_W-1:0];
        end
        CFG_MAP_HEIGHT: begin
          map_h_q <= (cfg_wdata_i[DIM_W-1:0] > MH_LIMIT) ? MH_LIMIT : cfg_wdata_i[DIM_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Decode the rectangle to walk: one cell for write and read, the clipped
  // fill rectangle otherwise
  always_comb begin
    mode_in = mode_e'(mode_i);
    ua      = unsigned'(col_a_i);
    ub      = unsigned'(row_a_i);
    mw32    = COORD_W'(map_w_q);
    mh32    = COORD_W'(map_h_q);
    xe_fill = (col_b_i < mw32) ? col_b_i[DIM_W-1:0] : map_w_q;
    ye_fill = (row_b_i < mh32) ? row_b_i[DIM_W-1:0] : map_h_q;
    in_map  = (ua < mw32) && (ub < mh32);
    fill_en = (ua < COORD_W'(xe_fill)) && (ub < COORD_W'(ye_fill));
  end

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= mode_in;
      value_q   <= FLAG_BITS'(tile_value_i);
      x0_q      <= ua[DIM_W-1:0];
      walk_en_q <= (mode_in == MODE_FILL) ? fill_en : in_map;
      xe_q      <= (mode_in == MODE_FILL) ? xe_fill : ua[DIM_W-1:0] + DIM_W'(1);
      ye_q      <= (mode_in == MODE_FILL) ? ye_fill : ub[DIM_W-1:0] + DIM_W'(1);
      pmin_x_q  <= probe_min_x_i;
      pmin_y_q  <= probe_min_y_i;
      pmax_x_q  <= probe_max_x_i;
      pmax_y_q  <= probe_max_y_i;
    end
  end

  // Advance the walk row by row
  always_comb begin
    x_nxt = cur_x_q + DIM_W'(1);
    y_nxt = cur_y_q + DIM_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_x_q <= ua[DIM_W-1:0];
      cur_y_q <= ub[DIM_W-1:0];
    end else if (cmd_i.walk_step) begin
      if (x_nxt < xe_q) begin
        cur_x_q <= x_nxt;
      end else begin
        cur_x_q <= x0_q;
        cur_y_q <= y_nxt;
      end
    end
  end

  // Form the flat cell address row * width + column
  assign prod = cur_y_q[ROW_W-1:0] * map_w_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_calc) begin
      addr_q <= ADDR_W'(prod + (ROW_W+DIM_W)'(cur_x_q));
    end
  end

  // Step the clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + (ADDR_W+1)'(1);
    end
  end

  // Share the single write port between clearing and item writes
  always_comb begin
    wr_en   = cmd_i.clear_step | cmd_i.mem_we;
    wr_addr = cmd_i.clear_step ? clr_q[ADDR_W-1:0] : addr_q;
    wr_data = cmd_i.clear_step ? FLAGS_NONE : value_q;
  end

  // Cell memory; the read lands directly in the result register
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.load) begin
      cell_q <= '0;
    end else if (cmd_i.mem_re) begin
      cell_q <= CELL_W'(mem[addr_q]);
    end
  end

  // Select edge and origin of the current lane and subtract
  always_comb begin
    unique case (lane_q)
      2'd0:    probe_sel = pmin_x_q;
      2'd1:    probe_sel = pmin_y_q;
      2'd2:    probe_sel = pmax_x_q;
      default: probe_sel = pmax_y_q;
    endcase
    org_sel  = lane_q[0] ? origin_y_q : origin_x_q;
    dividend = num_q[NUM_W-1] ? (~unsigned'(num_q) + NUM_W'(1)) : unsigned'(num_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sub) begin
      num_q <= {probe_sel[COORD_W-1], probe_sel} - {org_sel[COORD_W-1], org_sel};
    end
    if (cmd_i.div_start) begin
      neg_q <= num_q[NUM_W-1];
    end
  end

  tmsq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (tile_size_q),
    .idle_o     (div_idle),
    .quot_o     (quot),
    .rem_nz_o   (rem_nz)
  );

  // Floor the quotient, add one for the high edges, clamp to the map.
  // A negative numerator gives -q - (remainder nonzero), written as ~q + adj.
  always_comb begin
    lane_hi = lane_q[1];
    unique case ({lane_hi, rem_nz})
      2'b00:   neg_adj = 2'd1;
      2'b01:   neg_adj = 2'd0;
      2'b10:   neg_adj = 2'd2;
      default: neg_adj = 2'd1;
    endcase
    if (neg_q) begin
      tq = ~{2'b00, quot} + TILE_W'(neg_adj);
    end else begin
      tq = {2'b00, quot} + TILE_W'(lane_hi);
    end
    limit = lane_q[0] ? map_h_q : map_w_q;
    if (tq[TILE_W-1]) begin
      clamped = '0;
    end else if (tq > TILE_W'(limit)) begin
      clamped = limit;
    end else begin
      clamped = tq[DIM_W-1:0];
    end
  end

  // Advance the lane and keep its index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else if (cmd_i.load) begin
      lane_q <= '0;
    end else if (cmd_i.lane_store) begin
      lane_q <= lane_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 4; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.lane_store) begin
      win_q[lane_q] <= clamped;
    end
  end

  // Status toward the controller
  always_comb begin
    stat_o.mode       = mode_q;
    stat_o.clear_done = (clr_q == (ADDR_W+1)'(DEPTH));
    stat_o.walk_en    = walk_en_q;
    stat_o.walk_last  = (x_nxt >= xe_q) && (y_nxt >= ye_q);
    stat_o.div_idle   = div_idle;
    stat_o.lane_last  = (lane_q == 2'd3);
  end

  assign cell_value_o = cell_q;
  assign win_col_lo_o = win_q[0];
  assign win_row_lo_o = win_q[1];
  assign win_col_hi_o = win_q[2];
  assign win_row_hi_o = win_q[3];

endmodule

### hdl/tmsq_ctrl.sv
// ----------------------------------------------------------------------------
// tmsq_ctrl: controller of the tile map store
// Sequences the clearing pass, the cell walk of write, fill and read, and
// the four divider passes of a window query.
// ----------------------------------------------------------------------------
module tmsq_ctrl
  import tmsq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output logic     done_o,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  ctrl_state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.clear_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.clear_step = 1'b1;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.mode == MODE_WINDOW) begin
          state_d = ST_SUB;
        end else if (stat_i.walk_en) begin
          state_d = ST_ADDR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ADDR: begin
        cmd_o.addr_calc = 1'b1;
        state_d = (stat_i.mode == MODE_READ) ? ST_READ : ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.walk_step = 1'b1;
        state_d = stat_i.walk_last ? ST_DONE : ST_ADDR;
      end
      ST_READ: begin
        cmd_o.mem_re = 1'b1;
        state_d      = ST_DONE;
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat_i.div_idle) begin
          state_d = ST_FLOOR;
        end
      end
      ST_FLOOR: begin
        cmd_o.lane_store = 1'b1;
        state_d = stat_i.lane_last ? ST_DONE : ST_SUB;
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### hdl/tilemap_store_and_window_query.sv
// ----------------------------------------------------------------------------
// tilemap_store_and_window_query: tile map store with a window query
// A map of up to 256 x 256 flag cells with write, fill, read and a query
// that turns a 16.16 box into a clamped range of tile indices.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with an item on the input ports; the item transfers at a
//   clock edge where start is high and busy is low. Each item gives one
//   result, shown on the result ports for exactly one cycle while done_o is
//   high; unused result fields read zero. The receiver cannot stall.
//   Work between the transfer edge and the done_o cycle, in order:
//     write, read: decode, address, memory access;
//     write or read outside the map, empty fill: decode only;
//     fill: decode, then per cell of the clipped rectangle one address step
//       and one memory write on the single write port; window: decode, four
//       passes of one shared 33-step serial divider, then the result.
//   busy drops in the cycle after done_o, so a new item is taken only once
//   the previous one is done. Configuration writes through cfg_we_i /
//   cfg_idx_i / cfg_wdata_i take effect at once; the user must make them
//   while busy is low (the block does not enforce this). After reset the
//   block zeroes the cell memory, one cell a cycle, keeping busy high;
//   configuration writes are taken.
module tilemap_store_and_window_query
  import tmsq_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  output logic                      done_o,
  input  logic                      cfg_we_i,
  input  logic [IDX_W-1:0]          cfg_idx_i,
  input  logic [COORD_W-1:0]        cfg_wdata_i,
  input  logic [1:0]                mode_i,
  input  logic signed [COORD_W-1:0] col_a_i,
  input  logic signed [COORD_W-1:0] row_a_i,
  input  logic [COORD_W-1:0]        col_b_i,
  input  logic [COORD_W-1:0]        row_b_i,
  input  logic [CELL_W-1:0]         tile_value_i,
  input  logic signed [COORD_W-1:0] probe_min_x_i,
  input  logic signed [COORD_W-1:0] probe_min_y_i,
  input  logic signed [COORD_W-1:0] probe_max_x_i,
  input  logic signed [COORD_W-1:0] probe_max_y_i,
  output logic [CELL_W-1:0]         cell_value_o,
  output logic [DIM_W-1:0]          win_col_lo_o,
  output logic [DIM_W-1:0]          win_row_lo_o,
  output logic [DIM_W-1:0]          win_col_hi_o,
  output logic [DIM_W-1:0]          win_row_hi_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence the work
  tmsq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  // Store, walk and divide
  tmsq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mode_i        (mode_i),
    .col_a_i       (col_a_i),
    .row_a_i       (row_a_i),
    .col_b_i       (col_b_i),
    .row_b_i       (row_b_i),
    .tile_value_i  (tile_value_i),
    .probe_min_x_i (probe_min_x_i),
    .probe_min_y_i (probe_min_y_i),
    .probe_max_x_i (probe_max_x_i),
    .probe_max_y_i (probe_max_y_i),
    .cell_value_o  (cell_value_o),
    .win_col_lo_o  (win_col_lo_o),
    .win_row_lo_o  (win_row_lo_o),
    .win_col_hi_o  (win_col_hi_o),
    .win_row_hi_o  (win_row_hi_o)
  );

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the tile map store and window query
// Drives write, fill, read and window items through the start/busy handshake
// and checks every done_o result against a cycle-free predictor. The
// predictor keeps its own cell map and register copy. Directed corners come
// first, then random traffic over several map layouts.
// ----------------------------------------------------------------------------
module testbench;
  import tmsq_pkg::*;

  // Longest item is a full-map fill, plus the clear pass
  localparam int STALL_LIMIT = 500000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    mode_e              mode;
    logic [COORD_W-1:0] col_a;
    logic [COORD_W-1:0] row_a;
    logic [COORD_W-1:0] col_b;
    logic [COORD_W-1:0] row_b;
    logic [CELL_W-1:0]  tile_value;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
  } tile_query_t;

  typedef struct packed {
    logic [CELL_W-1:0] flags;
    logic [DIM_W-1:0]  col_lo;
    logic [DIM_W-1:0]  row_lo;
    logic [DIM_W-1:0]  col_hi;
    logic [DIM_W-1:0]  row_hi;
  } tile_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic                      done_o;
  logic                      cfg_we_i;
  logic [IDX_W-1:0]          cfg_idx_i;
  logic [COORD_W-1:0]        cfg_wdata_i;
  logic [1:0]                mode_i;
  logic signed [COORD_W-1:0] col_a_i;
  logic signed [COORD_W-1:0] row_a_i;
  logic [COORD_W-1:0]        col_b_i;
  logic [COORD_W-1:0]        row_b_i;
  logic [CELL_W-1:0]         tile_value_i;
  logic signed [COORD_W-1:0] probe_min_x_i;
  logic signed [COORD_W-1:0] probe_min_y_i;
  logic signed [COORD_W-1:0] probe_max_x_i;
  logic signed [COORD_W-1:0] probe_max_y_i;
  logic [CELL_W-1:0]         cell_value_o;
  logic [DIM_W-1:0]          win_col_lo_o;
  logic [DIM_W-1:0]          win_row_lo_o;
  logic [DIM_W-1:0]          win_col_hi_o;
  logic [DIM_W-1:0]          win_row_hi_o;

  // Shadow of the block: register copy and cell map
  longint            origin_x_m;
  longint            origin_y_m;
  longint            tile_size_m;
  int unsigned       map_w_m;
  int unsigned       map_h_m;
  logic [CELL_W-1:0] shadow_cells [DEPTH];

  tile_result_t expected_results [$];
  tile_result_t want_r;

  int gap_pct;
  int n_errors;
  int n_results;
  int n_reg_writes;
  int mode_seen [4];
  int stall_cycles;

  tilemap_store_and_window_query u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .done_o        (done_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mode_i        (mode_i),
    .col_a_i       (col_a_i),
    .row_a_i       (row_a_i),
    .col_b_i       (col_b_i),
    .row_b_i       (row_b_i),
    .tile_value_i  (tile_value_i),
    .probe_min_x_i (probe_min_x_i),
    .probe_min_y_i (probe_min_y_i),
    .probe_max_x_i (probe_max_x_i),
    .probe_max_y_i (probe_max_y_i),
    .cell_value_o  (cell_value_o),
    .win_col_lo_o  (win_col_lo_o),
    .win_row_lo_o  (win_row_lo_o),
    .win_col_hi_o  (win_col_hi_o),
    .win_row_hi_o  (win_row_hi_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Mirror one register write, with the block's masking and limits
  function automatic void apply_register(input logic [IDX_W-1:0] idx,
                                         input logic [COORD_W-1:0] data);
    logic [TS_W-1:0]  ts;
    logic [DIM_W-1:0] dim;
    ts  = data[TS_W-1:0];
    dim = data[DIM_W-1:0];
    case (idx)
      CFG_ORIGIN_X: begin
        origin_x_m = longint'($signed(data));
      end
      CFG_ORIGIN_Y: begin
        origin_y_m = longint'($signed(data));
      end
      CFG_TILE_SIZE: begin
        tile_size_m = (ts < TS_MIN) ? longint'(TS_MIN) : longint'({ts[TS_W-1:1], 1'b0});
      end
      CFG_MAP_WIDTH: begin
        map_w_m = (dim > MW_LIMIT) ? MAX_WIDTH : dim;
      end
      CFG_MAP_HEIGHT: begin
        map_h_m = (dim > MH_LIMIT) ? MAX_HEIGHT : dim;
      end
      default: begin
      end
    endcase
  endfunction

  // Floor division of an offset from the origin by the tile size
  function automatic longint floor_tile(input longint num);
    longint q;
    q = num / tile_size_m;
    if (num % tile_size_m != 0 && num < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_tile(input longint v, input int unsigned lim);
    if (v < 0) begin
      return '0;
    end
    if (v > longint'(lim)) begin
      return DIM_W'(lim);
    end
    return DIM_W'(v);
  endfunction

  // Apply one item to the shadow map and return the result it should give
  function automatic tile_result_t predict_tile_result(input tile_query_t q);
    tile_result_t     r;
    longint unsigned  x_end;
    longint unsigned  y_end;
    longint           sx;
    longint           sy;
    r = '0;
    case (q.mode)
      MODE_WRITE: begin
        if (q.col_a < map_w_m && q.row_a < map_h_m) begin
          shadow_cells[q.row_a * map_w_m + q.col_a] = q.tile_value;
        end
      end
      MODE_FILL: begin
        x_end = (q.col_b < map_w_m) ? q.col_b : map_w_m;
        y_end = (q.row_b < map_h_m) ? q.row_b : map_h_m;
        for (longint unsigned y = q.row_a; y < y_end; y++) begin
          for (longint unsigned x = q.col_a; x < x_end; x++) begin
            shadow_cells[y * map_w_m + x] = q.tile_value;
          end
        end
      end
      MODE_READ: begin
        sx = longint'($signed(q.col_a));
        sy = longint'($signed(q.row_a));
        if (sx >= 0 && sy >= 0 && sx < longint'(map_w_m) && sy < longint'(map_h_m)) begin
          r.flags = shadow_cells[sy * longint'(map_w_m) + sx];
        end
      end
      default: begin
        r.col_lo = clamp_tile(floor_tile(longint'($signed(q.min_x)) - origin_x_m), map_w_m);
        r.row_lo = clamp_tile(floor_tile(longint'($signed(q.min_y)) - origin_y_m), map_h_m);
        r.col_hi = clamp_tile(floor_tile(longint'($signed(q.max_x)) - origin_x_m) + 1, map_w_m);
        r.row_hi = clamp_tile(floor_tile(longint'($signed(q.max_y)) - origin_y_m) + 1, map_h_m);
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders; fields the mode does not use carry random junk
  // ---------------------------------------------------------------------------

  function automatic tile_query_t cell_op(input mode_e mode,
                                          input logic [COORD_W-1:0] col, row,
                                          input logic [COORD_W-1:0] col_end, row_end,
                                          input logic [CELL_W-1:0] value);
    tile_query_t q;
    q.mode       = mode;
    q.col_a      = col;
    q.row_a      = row;
    q.col_b      = col_end;
    q.row_b      = row_end;
    q.tile_value = value;
    q.min_x      = $urandom;
    q.min_y      = $urandom;
    q.max_x      = $urandom;
    q.max_y      = $urandom;
    return q;
  endfunction

  function automatic tile_query_t window_op(input logic [COORD_W-1:0] min_x, min_y,
                                            input logic [COORD_W-1:0] max_x, max_y);
    tile_query_t q;
    q.mode       = MODE_WINDOW;
    q.col_a      = $urandom;
    q.row_a      = $urandom;
    q.col_b      = $urandom;
    q.row_b      = $urandom;
    q.tile_value = CELL_W'($urandom_range(255));
    q.min_x      = min_x;
    q.min_y      = min_y;
    q.max_x      = max_x;
    q.max_y      = max_y;
    return q;
  endfunction

  // Mostly inside the map, some just past the edge, negative or wild
  function automatic logic [COORD_W-1:0] random_cell_coord(input int unsigned lim);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      return (lim == 0) ? '0 : COORD_W'($urandom_range(lim - 1));
    end else if (pick < 82) begin
      return COORD_W'(lim + $urandom_range(3));
    end else if (pick < 92) begin
      return COORD_W'(0 - $urandom_range(4, 1));
    end
    return $urandom;
  endfunction

  // Fill span: short runs mostly, some inverted, some open-ended near the edge
  function automatic void pick_span(input int unsigned lim,
                                    output logic [COORD_W-1:0] lo,
                                    output logic [COORD_W-1:0] hi);
    lo = random_cell_coord(lim);
    case ($urandom_range(9))
      0: begin
        hi = $urandom;
        if (lim > 4) begin
          lo = COORD_W'(lim - $urandom_range(4, 1));
        end
      end
      1: begin
        hi = lo - COORD_W'($urandom_range(3, 1));
      end
      default: begin
        hi = lo + COORD_W'($urandom_range(6));
      end
    endcase
  endfunction

  // Box edge a few tiles around the map, now and then anywhere
  function automatic logic [COORD_W-1:0] random_edge(input longint origin,
                                                     input int unsigned tiles);
    if ($urandom_range(99) < 15) begin
      return $urandom;
    end
    return COORD_W'(origin
                    + (longint'($urandom_range(2 * tiles + 8)) - longint'(tiles) - 4)
                      * tile_size_m
                    + longint'($urandom_range(32'(tile_size_m - 1))));
  endfunction

  function automatic logic [COORD_W-1:0] edge_after(input logic [COORD_W-1:0] lo);
    return COORD_W'(longint'($signed(lo))
                    + longint'($urandom_range(6)) * tile_size_m
                    + longint'($urandom_range(32'(tile_size_m - 1))));
  endfunction

  function automatic tile_query_t random_query();
    int unsigned        pick;
    logic [COORD_W-1:0] c0, c1, r0, r1, mx, my;
    pick = $urandom_range(99);
    if (pick < 30) begin
      return cell_op(MODE_WRITE, random_cell_coord(map_w_m), random_cell_coord(map_h_m),
                     $urandom, $urandom, CELL_W'($urandom_range(255)));
    end else if (pick < 45) begin
      pick_span(map_w_m, c0, c1);
      pick_span(map_h_m, r0, r1);
      return cell_op(MODE_FILL, c0, r0, c1, r1, CELL_W'($urandom_range(255)));
    end else if (pick < 80) begin
      return cell_op(MODE_READ, random_cell_coord(map_w_m), random_cell_coord(map_h_m),
                     $urandom, $urandom, CELL_W'($urandom_range(255)));
    end
    mx = random_edge(origin_x_m, map_w_m);
    my = random_edge(origin_y_m, map_h_m);
    return window_op(mx, my,
                     ($urandom_range(3) == 0) ? random_edge(origin_x_m, map_w_m) : edge_after(mx),
                     ($urandom_range(3) == 0) ? random_edge(origin_y_m, map_h_m) : edge_after(my));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one item, hold start until the transfer, then record its result
  task automatic issue_query(input tile_query_t q);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
      if ($urandom_range(1) == 1) begin
        while (busy !== 1'b0) @(posedge clk_i);
        repeat ($urandom_range(2)) @(posedge clk_i);
      end
    end
    mode_i        <= q.mode;
    col_a_i       <= q.col_a;
    row_a_i       <= q.row_a;
    col_b_i       <= q.col_b;
    row_b_i       <= q.row_b;
    tile_value_i  <= q.tile_value;
    probe_min_x_i <= q.min_x;
    probe_min_y_i <= q.min_y;
    probe_max_x_i <= q.max_x;
    probe_max_y_i <= q.max_y;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_results.push_back(predict_tile_result(q));
    mode_seen[q.mode]++;
  endtask

  // Drop start and hold until every pending result is in and busy is low
  task automatic wait_results_settled();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    wait_results_settled();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_register(idx, data);
    cfg_we_i <= 1'b0;
    n_reg_writes++;
  endtask

  task automatic load_layout(input logic [COORD_W-1:0] org_x, org_y, tile, width, height);
    write_register(CFG_ORIGIN_X, org_x);
    write_register(CFG_ORIGIN_Y, org_y);
    write_register(CFG_TILE_SIZE, tile);
    write_register(CFG_MAP_WIDTH, width);
    write_register(CFG_MAP_HEIGHT, height);
  endtask

  task automatic run_random_items(input int count);
    repeat (count) begin
      if ($urandom_range(49) == 0) begin
        wait_results_settled();
      end
      issue_query(random_query());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Map is empty after the clear pass; widest box spans the whole map
  task automatic test_after_clear();
    issue_query(cell_op(MODE_READ, 32'd0, 32'd0, $urandom, $urandom, 8'hFF));
    issue_query(window_op(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
  endtask

  // Corner cells, writes off the map dropped, reads off the map give empty
  task automatic test_cell_bounds();
    issue_query(cell_op(MODE_WRITE, 32'd0, 32'd0, $urandom, $urandom, 8'hFF));
    issue_query(cell_op(MODE_WRITE, 32'd255, 32'd255, $urandom, $urandom, 8'h01));
    issue_query(cell_op(MODE_WRITE, 32'd256, 32'd0, $urandom, $urandom, 8'hAA));
    issue_query(cell_op(MODE_WRITE, 32'hFFFF_FFFF, 32'd3, $urandom, $urandom, 8'h5A));
    issue_query(cell_op(MODE_READ, 32'd0, 32'd0, $urandom, $urandom, 8'h00));
    issue_query(cell_op(MODE_READ, 32'd255, 32'd255, $urandom, $urandom, 8'h00));
    issue_query(cell_op(MODE_READ, 32'hFFFF_FFFF, 32'd0, $urandom, $urandom, 8'h00));
    issue_query(cell_op(MODE_READ, 32'd0, 32'd256, $urandom, $urandom, 8'h00));
  endtask

  // Clipped, empty, inverted and full-map fills
  task automatic test_fill_clipping();
    issue_query(cell_op(MODE_FILL, 32'd250, 32'd250, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h55));
    issue_query(cell_op(MODE_FILL, 32'd5, 32'd5, 32'd5, 32'd9, 8'hEE));
    issue_query(cell_op(MODE_FILL, 32'd9, 32'd9, 32'd3, 32'd3, 8'hEE));
    issue_query(cell_op(MODE_READ, 32'd253, 32'd253, $urandom, $urandom, 8'h00));
    issue_query(cell_op(MODE_FILL, 32'd0, 32'd0, 32'd256, 32'd256, 8'h81));
    issue_query(cell_op(MODE_READ, 32'd128, 32'd77, $urandom, $urandom, 8'h00));
  endtask

  // Tile size forcing, origin extremes, floor on negative offsets
  task automatic test_register_extremes();
    write_register(CFG_TILE_SIZE, 32'd0);
    write_register(CFG_ORIGIN_X, 32'h7FFF_FFFF);
    write_register(CFG_ORIGIN_Y, 32'h8000_0000);
    issue_query(window_op(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    write_register(CFG_TILE_SIZE, 32'hFFFF_FFFF);
    write_register(CFG_ORIGIN_X, 32'd0);
    write_register(CFG_ORIGIN_Y, 32'd0);
    write_register(CFG_MAP_WIDTH, 32'd511);
    write_register(CFG_MAP_HEIGHT, 32'd257);
    issue_query(window_op(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    write_register(CFG_TILE_SIZE, 32'd1);
    write_register(CFG_TILE_SIZE, 32'd3);
    write_register(CFG_TILE_SIZE, 32'h0001_0001);
    write_register(CFG_ORIGIN_X, 32'h0003_0000);
    write_register(CFG_ORIGIN_Y, 32'hFFFE_0000);
    // indexes past the register list must be ignored
    for (int i = int'(CFG_MAP_HEIGHT) + 1; i < (1 << IDX_W); i++) begin
      write_register(IDX_W'(i), $urandom);
    end
    issue_query(window_op(32'h0001_8000, 32'hFFFE_8000, 32'h0002_FFFF, 32'h0001_0000));
  endtask

  // Zero width or height puts everything off the map
  task automatic test_empty_map();
    write_register(CFG_MAP_WIDTH, 32'hFFFF_FE00);
    write_register(CFG_MAP_HEIGHT, 32'hFFFF_0005);
    issue_query(cell_op(MODE_WRITE, 32'd0, 32'd0, $urandom, $urandom, 8'h7E));
    issue_query(cell_op(MODE_FILL, 32'd0, 32'd0, 32'd9, 32'd9, 8'h7E));
    issue_query(cell_op(MODE_READ, 32'd0, 32'd0, $urandom, $urandom, 8'h00));
    issue_query(window_op(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    write_register(CFG_MAP_WIDTH, 32'd5);
    write_register(CFG_MAP_HEIGHT, 32'd0);
    issue_query(cell_op(MODE_READ, 32'd0, 32'd0, $urandom, $urandom, 8'h00));
  endtask

  // Narrowing the map re-indexes the old contents without moving them
  task automatic test_map_resize();
    load_layout(32'd0, 32'd0, 32'h0001_0000, 32'd8, 32'd8);
    issue_query(cell_op(MODE_WRITE, 32'd3, 32'd1, $urandom, $urandom, 8'h3C));
    write_register(CFG_MAP_WIDTH, 32'd4);
    issue_query(cell_op(MODE_READ, 32'd3, 32'd2, $urandom, $urandom, 8'h00));
    issue_query(cell_op(MODE_READ, 32'd3, 32'd1, $urandom, $urandom, 8'h00));
  endtask

  task automatic test_random_small_maps();
    repeat (3) begin
      load_layout(COORD_W'($urandom_range(32'h8_0000) - 32'h4_0000),
                  COORD_W'($urandom_range(32'h8_0000) - 32'h4_0000),
                  COORD_W'(32'h1_0000 * $urandom_range(8, 1)),
                  COORD_W'($urandom_range(24, 1)), COORD_W'($urandom_range(24, 1)));
      run_random_items(100);
    end
  endtask

  // Back-to-back transfers with no random sender gaps
  task automatic test_random_no_gaps();
    gap_pct = 0;
    load_layout($urandom, $urandom, COORD_W'($urandom_range(32'h4_0000, 2)),
                COORD_W'($urandom_range(16, 1)), COORD_W'($urandom_range(16, 1)));
    run_random_items(150);
    gap_pct = 15;
  endtask

  // Widths above the limit clamp to the full map
  task automatic test_random_full_map();
    load_layout($urandom, $urandom, COORD_W'(32'h1_0000 * $urandom_range(16, 1)),
                32'd300, 32'd511);
    run_random_items(150);
  endtask

  task automatic test_random_odd_settings();
    repeat (2) begin
      load_layout($urandom, $urandom, $urandom,
                  COORD_W'($urandom_range(40)), COORD_W'($urandom_range(40)));
      run_random_items(75);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string field, input logic [DIM_W-1:0] want,
                             input logic [DIM_W-1:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= REPORT_MAX) begin
        $display("mismatch at %0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    end
  endtask

  // Compare each strobed result with the oldest pending one
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_MAX) begin
          $display("mismatch at %0t: result strobe with no transfer pending", $time);
        end
      end else begin
        want_r = expected_results.pop_front();
        check_field("cell_value", want_r.flags, cell_value_o);
        check_field("win_col_lo", want_r.col_lo, win_col_lo_o);
        check_field("win_row_lo", want_r.row_lo, win_row_lo_o);
        check_field("win_col_hi", want_r.col_hi, win_col_hi_o);
        check_field("win_row_hi", want_r.row_hi, win_row_hi_o);
        n_results++;
      end
    end
  end

  // Stop a hung run: count cycles with neither a transfer nor a result
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (start === 1'b1 && busy === 1'b0) || done_o === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer or result for %0d cycles", stall_cycles);
      $display("testbench: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_ORIGIN_X;
    cfg_wdata_i   <= '0;
    mode_i        <= MODE_WRITE;
    col_a_i       <= '0;
    row_a_i       <= '0;
    col_b_i       <= '0;
    row_b_i       <= '0;
    tile_value_i  <= '0;
    probe_min_x_i <= '0;
    probe_min_y_i <= '0;
    probe_max_x_i <= '0;
    probe_max_y_i <= '0;
    origin_x_m  = 0;
    origin_y_m  = 0;
    tile_size_m = longint'(TS_RESET);
    map_w_m     = MW_RESET;
    map_h_m     = MH_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_cells[i] = FLAGS_NONE;
    end
    gap_pct = 15;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_after_clear();
    test_cell_bounds();
    test_fill_clipping();
    test_register_extremes();
    test_empty_map();
    test_map_resize();
    test_random_small_maps();
    test_random_no_gaps();
    test_random_full_map();
    test_random_odd_settings();

    // Let the last result land, then idle so that any stray result strobe is caught
    wait_results_settled();
    repeat (160) @(posedge clk_i);
    n_errors += expected_results.size();

    $display("covered %0d writes, %0d fills, %0d reads, %0d window queries; %0d results checked",
             mode_seen[MODE_WRITE], mode_seen[MODE_FILL], mode_seen[MODE_READ],
             mode_seen[MODE_WINDOW], n_results);
    $display("%0d register writes over directed corners and random layouts, %0d mismatches",
             n_reg_writes, n_errors);
    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### sim.f
hdl/tmsq_pkg.sv
hdl/tmsq_div.sv
hdl/tmsq_dp.sv
hdl/tmsq_ctrl.sv
hdl/tilemap_store_and_window_query.sv
bench/testbench.sv
